FILE: design/mbt_pkg.sv
package mbt_pkg;

    // Pattern geometry
    localparam int MAX_EXTENT  = 16384;
    localparam int BLOCK_SIZE  = 32;
    localparam int BLOCK_STEP  = 8;
    localparam int BLINK_SIZE  = 16;
    localparam int FULL_PERIOD = 60;

    // Field widths
    localparam int EXT_W   = 15;
    localparam int COORD_W = 14;
    localparam int COLOR_W = 8;
    localparam int FRAME_W = 32;

    // Column mark memory: one row holds the marks of ROW_COLS columns and an epoch tag
    localparam int ROW_COLS = 32;
    localparam int COL_W    = $clog2(ROW_COLS);
    localparam int ROWS     = MAX_EXTENT / ROW_COLS;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int EPOCH_W  = 8;
    localparam int MROW_W   = EXT_W + 1 - COL_W;

    localparam int PHASE_W  = $clog2(FULL_PERIOD + 1);

    // Divider: two quotient bits per cycle
    localparam int LEFT_W       = FRAME_W + $clog2(BLOCK_STEP + 1);
    localparam int DIV_BITS     = LEFT_W + (LEFT_W % 2);
    localparam int DIV_CNT_W    = $clog2(DIV_BITS / 2 + 1);
    localparam int SHORT_CYCLES = COLOR_W / 2;
    localparam int PROD_W       = COORD_W + COLOR_W;

    // Register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    // Commands
    localparam logic CMD_RENDER = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Colours
    localparam logic [COLOR_W-1:0] GRAD_RED = 8'h20;
    localparam logic [COLOR_W-1:0] GRAY     = 8'h20;
    localparam logic [COLOR_W-1:0] ORANGE_B = 8'hF0;
    localparam logic [COLOR_W-1:0] ORANGE_G = 8'h80;
    localparam logic [COLOR_W-1:0] ORANGE_R = 8'h10;
    localparam logic [COLOR_W-1:0] BLINK_HI = 8'hFF;
    localparam logic [COLOR_W-1:0] BLINK_LO = 8'h10;
    localparam logic [COLOR_W-1:0] ALPHA    = 8'hFF;
    localparam int                 SCALE    = 255;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] cycles;
        logic [EXT_W-1:0]     rem_init;
        logic [DIV_BITS-1:0]  bits;
        logic [EXT_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [COLOR_W-1:0] quo;
        logic [EXT_W-1:0]   rem;
    } div_rsp_t;

endpackage

FILE: design/mbt_div.sv
module mbt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  mbt_pkg::div_req_t req,
    output mbt_pkg::div_rsp_t rsp
);
    import mbt_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [EXT_W-1:0]     rem_reg, rem_next;
    logic [DIV_BITS-1:0]  bits_reg, bits_next;
    logic [COLOR_W-1:0]   quo_reg, quo_next;
    logic [EXT_W-1:0]     div_reg, div_next;

    // Two restoring steps per cycle, dividend bits taken MSB first
    always_comb
    begin
        logic [EXT_W:0]   r1;
        logic [EXT_W:0]   r2;
        logic [EXT_W:0]   d;
        logic [EXT_W-1:0] rem1;
        logic             ge1;
        logic             ge2;
        d    = {1'b0, div_reg};
        r1   = {rem_reg, bits_reg[DIV_BITS-1]};
        ge1  = (r1 >= d);
        rem1 = ge1 ? EXT_W'(r1 - d) : r1[EXT_W-1:0];
        r2   = {rem1, bits_reg[DIV_BITS-2]};
        ge2  = (r2 >= d);

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        bits_next = bits_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.cycles;
            rem_next  = req.rem_init;
            bits_next = req.bits;
            quo_next  = '0;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge2 ? EXT_W'(r2 - d) : r2[EXT_W-1:0];
            bits_next = {bits_reg[DIV_BITS-3:0], 2'b00};
            quo_next  = {quo_reg[COLOR_W-3:0], ge1, ge2};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        quo_reg  <= quo_next;
        div_reg  <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: design/moving_block_test_pattern.sv
// Moving-block BGRA test pattern generator.
// Input stream (s_*): s_tuser is the command (0 render next frame, 1 read pixel),
// s_tdata carries the pixel coordinate. Every accepted item gives exactly one
// result on the output stream (m_*): the pixel bytes, the last rendered frame
// index and the full_refresh / outside_frame flags.
// The user writes width and height via cfg_we/cfg_index/cfg_data only while idle; unenforced.
// Column marks live in a 512 x 40 bit memory, 32 columns per row with an epoch
// tag; a full refresh bumps the epoch instead of clearing the memory.
// Path from the input transfer to the result, through the shared
// two-bit-per-cycle divider and the mark memory read-modify-write port:
//   read inside the frame: two divisions (blue, then green), then the finish step
//   read outside the frame: straight to the finish step
//   render: straight on for a full refresh, otherwise a read and a write per mark
//   row; then a division recomputes the block position before the next item is taken
//   writing the width also triggers that division.
// Reset: a clearing pass sweeps the 512 rows of the mark memory, with s_tready low.
// The same pass runs once every 255 full refreshes, when the epoch tag wraps.
// The result is held in an output register; then the block is idle again and takes the
// next item once the block position is current; loading waits while a result is untaken.
module moving_block_test_pattern (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // pixel_x[13:0], pixel_y[27:14], zero pad
    input  logic                           s_tuser,   // command
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata,   // blue, green, red, alpha, frame_number
    output logic [1:0]                     m_tuser,   // full_refresh, outside_frame
    input  logic                           cfg_we,
    input  logic [mbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbt_pkg::EXT_W-1:0]      cfg_data
);
    import mbt_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_LEFT    = 8'b0000_0100,
        ST_MARK_RD = 8'b0000_1000,
        ST_MARK_WR = 8'b0001_0000,
        ST_BLUE    = 8'b0010_0000,
        ST_GREEN   = 8'b0100_0000,
        ST_FINISH  = 8'b1000_0000
    } state_t;

    localparam int MEM_W = EPOCH_W + ROW_COLS;

    state_t               state_reg, state_next;
    logic [EXT_W-1:0]     width_reg, width_next;
    logic [EXT_W-1:0]     height_reg, height_next;
    logic [FRAME_W-1:0]   frame_cnt_reg, frame_cnt_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [FRAME_W-1:0]   last_frame_reg, last_frame_next;
    logic                 last_full_reg, last_full_next;
    logic                 rendered_reg, rendered_next;
    logic [EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic [EXT_W-1:0]     left_reg, left_next;
    logic                 left_stale_reg, left_stale_next;
    logic                 clear_pend_reg, clear_pend_next;
    logic [ROW_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [MROW_W-1:0]    row_reg, row_next;
    logic [MROW_W-1:0]    last_row_reg, last_row_next;
    logic [COORD_W-1:0]   px_reg, px_next;
    logic [COORD_W-1:0]   py_reg, py_next;
    logic [COLOR_W-1:0]   blue_reg, blue_next;
    logic [COLOR_W-1:0]   res_b_reg, res_b_next;
    logic [COLOR_W-1:0]   res_g_reg, res_g_next;
    logic [COLOR_W-1:0]   res_r_reg, res_r_next;
    logic [COLOR_W-1:0]   res_a_reg, res_a_next;
    logic                 res_out_reg, res_out_next;
    logic                 m_valid_reg, m_valid_next;
    logic [63:0]          out_data_reg, out_data_next;
    logic [1:0]           out_user_reg, out_user_next;

    logic [MEM_W-1:0]     mark_mem [ROWS];
    logic [MEM_W-1:0]     rd_data_reg;
    logic                 mem_we;
    logic [ROW_W-1:0]     mem_waddr;
    logic [MEM_W-1:0]     mem_wdata;
    logic [ROW_W-1:0]     mem_raddr;

    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic [EXT_W-1:0]     span;
    logic [EXT_W-1:0]     lim;
    logic [ROW_COLS-1:0]  row_mask;
    logic [COORD_W-1:0]   in_x;
    logic [COORD_W-1:0]   in_y;

    assign in_x = s_tdata[COORD_W-1:0];
    assign in_y = s_tdata[2*COORD_W-1:COORD_W];

    assign span = (width_reg > EXT_W'(BLOCK_SIZE)) ? width_reg - EXT_W'(BLOCK_SIZE)
                                                   : EXT_W'(1);
    assign lim  = (width_reg > EXT_W'(MAX_EXTENT)) ? EXT_W'(MAX_EXTENT) : width_reg;

    assign s_tready = (state_reg == ST_IDLE) && !left_stale_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Columns of the current row covered by the previous block, clipped to the frame
    always_comb
    begin
        logic [EXT_W:0] col;
        logic [EXT_W:0] blk_end;
        blk_end = {1'b0, left_reg} + (EXT_W + 1)'(BLOCK_SIZE);
        for (int j = 0; j < ROW_COLS; j++)
        begin
            col         = {row_reg, COL_W'(j)};
            row_mask[j] = (col >= {1'b0, left_reg}) && (col < blk_end) && (col < {1'b0, lim});
        end
    end

    assign mem_raddr = (state_reg == ST_MARK_RD) ? row_reg[ROW_W-1:0]
                                                 : px_reg[COORD_W-1:COL_W];

    always_comb
    begin
        logic [PROD_W-1:0]      prod;
        logic [EXT_W:0]         band_top;
        logic                   in_band;
        logic                   marked;
        logic                   in_block;
        logic signed [EXT_W+1:0] bl;
        logic signed [EXT_W+1:0] bt;
        logic signed [EXT_W+1:0] sx;
        logic signed [EXT_W+1:0] sy;
        logic                   in_blink;
        logic [COLOR_W-1:0]     level;
        logic [EPOCH_W-1:0]     rd_tag;
        logic [ROW_COLS-1:0]    rd_bits;

        state_next      = state_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        frame_cnt_next  = frame_cnt_reg;
        phase_next      = phase_reg;
        last_frame_next = last_frame_reg;
        last_full_next  = last_full_reg;
        rendered_next   = rendered_reg;
        epoch_next      = epoch_reg;
        left_next       = left_reg;
        left_stale_next = left_stale_reg;
        clear_pend_next = clear_pend_reg;
        clr_cnt_next    = clr_cnt_reg;
        row_next        = row_reg;
        last_row_next   = last_row_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        blue_next       = blue_reg;
        res_b_next      = res_b_reg;
        res_g_next      = res_g_reg;
        res_r_next      = res_r_reg;
        res_a_next      = res_a_reg;
        res_out_next    = res_out_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        mem_we    = 1'b0;
        mem_waddr = row_reg[ROW_W-1:0];
        mem_wdata = '0;

        div_req          = '0;
        div_req.divisor  = width_reg;
        div_req.cycles   = DIV_CNT_W'(SHORT_CYCLES);

        prod   = '0;
        rd_tag  = rd_data_reg[MEM_W-1:ROW_COLS];
        rd_bits = rd_data_reg[ROW_COLS-1:0];

        band_top = {3'b000, height_reg[EXT_W-1:2]};
        in_band  = ({2'b00, py_reg} >= band_top)
                && ({2'b00, py_reg} < band_top + (EXT_W + 1)'(BLOCK_SIZE));
        marked   = (rd_tag == epoch_reg) && rd_bits[px_reg[COL_W-1:0]];
        in_block = ({1'b0, px_reg} >= left_reg)
                && ({2'b00, px_reg} < {1'b0, left_reg} + (EXT_W + 1)'(BLOCK_SIZE));
        bl       = $signed({2'b00, width_reg}) - $signed((EXT_W + 2)'(2 * BLINK_SIZE));
        bt       = $signed({2'b00, height_reg}) - $signed((EXT_W + 2)'(2 * BLINK_SIZE));
        sx       = $signed({3'b000, px_reg}) + $signed((EXT_W + 2)'(0));
        sy       = $signed({3'b000, py_reg}) + $signed((EXT_W + 2)'(0));
        in_blink = (sx >= bl) && (sx < bl + $signed((EXT_W + 2)'(BLINK_SIZE)))
                && (sy >= bt) && (sy < bt + $signed((EXT_W + 2)'(BLINK_SIZE)));
        level    = last_frame_reg[0] ? BLINK_HI : BLINK_LO;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + ROW_W'(1);
                if (clr_cnt_reg == ROW_W'(ROWS - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = clear_pend_reg ? ST_FINISH : ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (left_stale_reg)
                begin
                    // block position of the last frame under the current width
                    div_req.start    = 1'b1;
                    div_req.cycles   = DIV_CNT_W'(DIV_BITS / 2);
                    div_req.rem_init = '0;
                    div_req.bits     = DIV_BITS'(last_frame_reg) * DIV_BITS'(BLOCK_STEP);
                    div_req.divisor  = span;
                    left_stale_next  = 1'b0;
                    state_next       = ST_LEFT;
                end
                else if (s_tvalid)
                begin
                    px_next      = in_x;
                    py_next      = in_y;
                    res_b_next   = '0;
                    res_g_next   = '0;
                    res_r_next   = '0;
                    res_a_next   = '0;
                    res_out_next = 1'b0;
                    if (s_tuser == CMD_RENDER)
                    begin
                        frame_cnt_next  = frame_cnt_reg + FRAME_W'(1);
                        if ((frame_cnt_reg == '1) || (phase_reg == PHASE_W'(FULL_PERIOD - 1)))
                            phase_next = '0;
                        else
                            phase_next = phase_reg + PHASE_W'(1);
                        last_frame_next = frame_cnt_reg;
                        last_full_next  = (phase_reg == '0);
                        rendered_next   = 1'b1;
                        left_stale_next = 1'b1;
                        if (phase_reg == '0)
                        begin
                            // new epoch invalidates all marks; sweep when the tag wraps
                            if (epoch_reg == '1)
                            begin
                                epoch_next      = EPOCH_W'(1);
                                clear_pend_next = 1'b1;
                                state_next      = ST_CLEAR;
                            end
                            else
                            begin
                                epoch_next = epoch_reg + EPOCH_W'(1);
                                state_next = ST_FINISH;
                            end
                        end
                        else
                        begin
                            row_next      = MROW_W'(left_reg >> COL_W);
                            last_row_next = MROW_W'(({1'b0, left_reg}
                                            + (EXT_W + 1)'(BLOCK_SIZE - 1)) >> COL_W);
                            state_next    = ST_MARK_RD;
                        end
                    end
                    else if ((EXT_W'(in_x) >= width_reg) || (EXT_W'(in_y) >= height_reg))
                    begin
                        res_out_next = 1'b1;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        prod             = PROD_W'(in_x) * PROD_W'(SCALE);
                        div_req.start    = 1'b1;
                        div_req.rem_init = EXT_W'(prod[PROD_W-1:COLOR_W]);
                        div_req.bits     = {prod[COLOR_W-1:0], (DIV_BITS - COLOR_W)'(0)};
                        div_req.divisor  = width_reg;
                        state_next       = ST_BLUE;
                    end
                end
            end

            ST_LEFT:
            begin
                if (div_rsp.done)
                begin
                    left_next  = div_rsp.rem;
                    state_next = ST_IDLE;
                end
            end

            ST_MARK_RD:
            begin
                if ((row_reg >= MROW_W'(ROWS)) || (row_reg > last_row_reg))
                    state_next = ST_FINISH;
                else
                    state_next = ST_MARK_WR;
            end

            ST_MARK_WR:
            begin
                // merge with the stored row only if its tag belongs to this epoch
                mem_we     = 1'b1;
                mem_waddr  = row_reg[ROW_W-1:0];
                mem_wdata  = {epoch_reg,
                              ((rd_tag == epoch_reg) ? rd_bits : ROW_COLS'(0)) | row_mask};
                row_next   = row_reg + MROW_W'(1);
                state_next = ST_MARK_RD;
            end

            ST_BLUE:
            begin
                if (div_rsp.done)
                begin
                    blue_next        = div_rsp.quo;
                    prod             = PROD_W'(py_reg) * PROD_W'(SCALE);
                    div_req.start    = 1'b1;
                    div_req.rem_init = EXT_W'(prod[PROD_W-1:COLOR_W]);
                    div_req.bits     = {prod[COLOR_W-1:0], (DIV_BITS - COLOR_W)'(0)};
                    div_req.divisor  = height_reg;
                    state_next       = ST_GREEN;
                end
            end

            ST_GREEN:
            begin
                if (div_rsp.done)
                begin
                    res_b_next = blue_reg;
                    res_g_next = div_rsp.quo;
                    res_r_next = GRAD_RED;
                    res_a_next = ALPHA;
                    if (rendered_reg && !last_full_reg)
                    begin
                        // paint order: gray marks, block, blink square on top
                        if (in_blink)
                        begin
                            res_b_next = level;
                            res_g_next = level;
                            res_r_next = level;
                        end
                        else if (in_band && in_block)
                        begin
                            res_b_next = ORANGE_B;
                            res_g_next = ORANGE_G;
                            res_r_next = ORANGE_R;
                        end
                        else if (in_band && marked)
                        begin
                            res_b_next = GRAY;
                            res_g_next = GRAY;
                            res_r_next = GRAY;
                        end
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next    = 1'b1;
                    out_data_next   = {last_frame_reg, res_a_reg, res_r_reg,
                                       res_g_reg, res_b_reg};
                    out_user_next   = {res_out_reg, rendered_reg && last_full_reg};
                    clear_pend_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:
                begin
                    width_next      = cfg_data;
                    left_stale_next = 1'b1;
                end
                REG_HEIGHT:
                begin
                    height_next = cfg_data;
                end
                default:
                begin
                    height_next = height_reg;
                end
            endcase
        end
    end

    mbt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mark_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mark_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            width_reg      <= EXT_W'(640);
            height_reg     <= EXT_W'(480);
            frame_cnt_reg  <= '0;
            phase_reg      <= '0;
            last_frame_reg <= '0;
            last_full_reg  <= 1'b0;
            rendered_reg   <= 1'b0;
            epoch_reg      <= EPOCH_W'(1);
            left_reg       <= '0;
            left_stale_reg <= 1'b0;
            clear_pend_reg <= 1'b0;
            clr_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            frame_cnt_reg  <= frame_cnt_next;
            phase_reg      <= phase_next;
            last_frame_reg <= last_frame_next;
            last_full_reg  <= last_full_next;
            rendered_reg   <= rendered_next;
            epoch_reg      <= epoch_next;
            left_reg       <= left_next;
            left_stale_reg <= left_stale_next;
            clear_pend_reg <= clear_pend_next;
            clr_cnt_reg    <= clr_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        last_row_reg <= last_row_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        blue_reg     <= blue_next;
        res_b_reg    <= res_b_next;
        res_g_reg    <= res_g_next;
        res_r_reg    <= res_r_next;
        res_a_reg    <= res_a_next;
        res_out_reg  <= res_out_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transfer taken while an item is in progress");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_LEFT || state_reg == ST_BLUE
                          || state_reg == ST_GREEN))
        else $error("divider finished with no state waiting for it");

    a_mark_after_partial: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARK_WR) |-> (rendered_reg && !last_full_reg))
        else $error("column marks written outside a partial render");

    a_left_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !left_stale_reg) |-> (left_reg < span))
        else $error("block position outside its span");

endmodule
